// ----- sv/stream_find_replace_macros.svh -----
// Assertion macros shared by the stream find-and-replace block.
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sfr_pkg.sv -----
// Package with types and constants of the stream find-and-replace block.
`timescale 1ns / 1ps

package sfr_pkg;

    localparam int DEF_MAX_PATTERN     = 8;
    localparam int DEF_MAX_REPLACEMENT = 8;
    localparam int LEN_W               = 4;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_INDEX_W         = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_BYTES      = 2'd0,
        CFG_PATTERN_LENGTH     = 2'd1,
        CFG_REPLACEMENT_BYTES  = 2'd2,
        CFG_REPLACEMENT_LENGTH = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       string_done;
    } t_out;

    typedef struct packed {
        logic [LEN_W-1:0] count;
        logic             has_byte;
        logic             string_end;
    } t_burst_ctl;

endpackage

// ----- sv/stream_find_replace.sv -----
// Top level of the streaming byte find-and-replace block.
// The input channel takes one byte beat per cycle unless stalled, with a last flag
// on the final byte of each string, and the output channel gives rewritten bytes.
// Every leftmost, non-overlapping occurrence of the configured pattern is
// replaced by the configured replacement, and pending bytes flush at last.
// The configuration channel writes pattern, pattern length, replacement and
// replacement length; a pattern length write drops the pending window.
// An accepted beat lands in an input register, and its first result goes into the
// output register once that is free. A beat that only fills the window gives no
// result. Throughput is one beat per cycle while each beat yields at most one
// result and no stall holds the output. A beat with n results holds the output
// register until all n have left, one per cycle unless stalled, and the input
// stalls once the input register is full. A last beat that yields no bytes gives
// one end marker with has_byte low. A stalled receiver freezes the output beat
// and backs up into o_in_stall. Reset clears the window count, both valid flags,
// the pattern, replacement and replacement length, and sets pattern length to one.
`timescale 1ns / 1ps

module stream_find_replace import sfr_pkg::*; #(
    parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in                    i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out                   o_out_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

`include "stream_find_replace_macros.svh"

    localparam int BurstMax = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN
                                                              : MAX_REPLACEMENT;

    logic [CFG_DATA_W-1:0]  r_pattern;
    logic [LEN_W-1:0]       r_plen;
    logic [CFG_DATA_W-1:0]  r_repl;
    logic [LEN_W-1:0]       r_rlen;
    logic                   r_iv;
    t_in                    r_in;
    logic                   cfg_we;
    logic                   plen_clr;
    logic                   in_take;
    logic                   fire;
    logic                   burst_free;
    logic [8*BurstMax-1:0]  burst_bytes;
    t_burst_ctl             burst_ctl;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign plen_clr    = cfg_we && (t_cfg_reg'(i_cfg_index) == CFG_PATTERN_LENGTH);

    assign fire       = r_iv && burst_free;
    assign o_in_stall = r_iv && !burst_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_plen    <= LEN_W'(1);
            r_repl    <= '0;
            r_rlen    <= '0;
        end else if (cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_PATTERN_BYTES:      r_pattern <= i_cfg_data;
                CFG_PATTERN_LENGTH:     r_plen    <= i_cfg_data[LEN_W-1:0];
                CFG_REPLACEMENT_BYTES:  r_repl    <= i_cfg_data;
                CFG_REPLACEMENT_LENGTH: r_rlen    <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (in_take) begin
            r_iv <= 1'b1;
        end else if (fire) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    sfr_window #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT),
        .BURST_MAX       (BurstMax)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (plen_clr),
        .i_fire    (fire),
        .i_item    (r_in),
        .i_pattern (r_pattern),
        .i_plen    (r_plen),
        .i_repl    (r_repl),
        .i_rlen    (r_rlen),
        .o_bytes   (burst_bytes),
        .o_ctl     (burst_ctl)
    );

    sfr_burst #(
        .BURST_MAX (BurstMax)
    ) u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && (burst_ctl.count != '0)),
        .i_bytes (burst_bytes),
        .i_ctl   (burst_ctl),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_free  (burst_free)
    );

    `SFR_ASSERT_NOW(a_done_is_run_last, i_clk, i_rst_n,
        o_out_valid && o_out_data.string_done, o_out_data.run_last,
        "string end beat is not the last beat of its burst")
    `SFR_ASSERT_NOW(a_empty_marker_ends, i_clk, i_rst_n,
        o_out_valid && !o_out_data.has_byte,
        o_out_data.run_last && o_out_data.string_done,
        "empty marker does not close the string")
    `SFR_ASSERT_NEXT(a_burst_continues, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_out_data.run_last, o_out_valid,
        "burst broke off before its last beat")
    `SFR_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n,
        o_in_stall, r_iv && o_out_valid,
        "input stalled without a held item and a busy output")

endmodule

// ----- sv/sfr_window.sv -----
// Pending window, pattern compare and result burst builder.
`timescale 1ns / 1ps

module sfr_window import sfr_pkg::*; #(
    parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
    parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT,
    parameter int BURST_MAX       = DEF_MAX_PATTERN
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clr,
    input  logic                   i_fire,
    input  t_in                    i_item,
    input  logic [CFG_DATA_W-1:0]  i_pattern,
    input  logic [LEN_W-1:0]       i_plen,
    input  logic [CFG_DATA_W-1:0]  i_repl,
    input  logic [LEN_W-1:0]       i_rlen,
    output logic [8*BURST_MAX-1:0] o_bytes,
    output t_burst_ctl             o_ctl
);

    localparam int PcW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int WinN = BURST_MAX + 1;

    logic [PcW-1:0]             r_pcnt;
    logic [PcW-1:0]             n_pcnt;
    logic [8*MAX_PATTERN-1:0]   r_win;
    logic [8*MAX_PATTERN-1:0]   n_win;

    logic [LEN_W-1:0] plen_eff;
    logic [LEN_W-1:0] rlen_eff;
    logic [LEN_W-1:0] pcnt_eff;
    logic [LEN_W-1:0] total;
    logic [LEN_W-1:0] n_res;
    logic [8*WinN-1:0] win;
    logic              cmp;
    logic              hit;

    always_comb begin
        if (i_plen == '0) begin
            plen_eff = LEN_W'(1);
        end else if (i_plen > LEN_W'(MAX_PATTERN)) begin
            plen_eff = LEN_W'(MAX_PATTERN);
        end else begin
            plen_eff = i_plen;
        end
        if (i_rlen > LEN_W'(MAX_REPLACEMENT)) begin
            rlen_eff = LEN_W'(MAX_REPLACEMENT);
        end else begin
            rlen_eff = i_rlen;
        end
        if (LEN_W'(r_pcnt) > plen_eff - LEN_W'(1)) begin
            pcnt_eff = plen_eff - LEN_W'(1);
        end else begin
            pcnt_eff = LEN_W'(r_pcnt);
        end
        total = pcnt_eff + LEN_W'(1);
    end

    always_comb begin
        win = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (LEN_W'(i) < pcnt_eff) begin
                win[8*i +: 8] = r_win[8*i +: 8];
            end else if (LEN_W'(i) == pcnt_eff) begin
                win[8*i +: 8] = i_item.in_byte;
            end
        end
    end

    always_comb begin
        cmp = (total == plen_eff);
        hit = cmp;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (LEN_W'(i) < plen_eff && win[8*i +: 8] != i_pattern[8*i +: 8]) begin
                hit = 1'b0;
            end
        end
    end

    always_comb begin
        if (hit) begin
            n_res = rlen_eff;
        end else if (cmp) begin
            n_res = i_item.in_last ? plen_eff : LEN_W'(1);
        end else begin
            n_res = i_item.in_last ? total : '0;
        end

        o_bytes = '0;
        for (int j = 0; j < BURST_MAX; j++) begin
            if (n_res != '0) begin
                o_bytes[8*j +: 8] = hit ? i_repl[8*j +: 8] : win[8*j +: 8];
            end
        end

        o_ctl.has_byte   = (n_res != '0);
        o_ctl.string_end = i_item.in_last;
        if (n_res == '0 && i_item.in_last) begin
            o_ctl.count = LEN_W'(1);
        end else begin
            o_ctl.count = n_res;
        end
    end

    always_comb begin
        n_pcnt = r_pcnt;
        n_win  = r_win;
        if (i_clr) begin
            n_pcnt = '0;
        end else if (i_fire) begin
            if (i_item.in_last || hit) begin
                n_pcnt = '0;
            end else if (cmp) begin
                n_pcnt = PcW'(plen_eff - LEN_W'(1));
                n_win  = win[8 +: 8*MAX_PATTERN];
            end else begin
                n_pcnt = PcW'(total);
                n_win  = win[8*MAX_PATTERN-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= '0;
        end else begin
            r_pcnt <= n_pcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

// ----- sv/sfr_burst.sv -----
// Result register handing out a burst of result beats one per cycle unless stalled.
`timescale 1ns / 1ps

module sfr_burst import sfr_pkg::*; #(
    parameter int BURST_MAX = DEF_MAX_PATTERN
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic [8*BURST_MAX-1:0] i_bytes,
    input  t_burst_ctl             i_ctl,
    input  logic                   i_stall,
    output logic                   o_valid,
    output t_out                   o_data,
    output logic                   o_free
);

    logic                   r_bv;
    logic [8*BURST_MAX-1:0] r_q;
    logic [LEN_W-1:0]       r_left;
    logic                   r_has;
    logic                   r_end;
    logic                   beat;
    logic                   final_beat;

    assign beat       = r_bv && !i_stall;
    assign final_beat = beat && (r_left == LEN_W'(1));
    assign o_free     = !r_bv || final_beat;

    assign o_valid            = r_bv;
    assign o_data.out_byte    = r_q[7:0];
    assign o_data.has_byte    = r_has;
    assign o_data.run_last    = (r_left == LEN_W'(1));
    assign o_data.string_done = (r_left == LEN_W'(1)) && r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv   <= 1'b0;
            r_left <= '0;
        end else if (i_load) begin
            r_bv   <= 1'b1;
            r_left <= i_ctl.count;
        end else if (final_beat) begin
            r_bv   <= 1'b0;
        end else if (beat) begin
            r_left <= r_left - LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q   <= i_bytes;
            r_has <= i_ctl.has_byte;
            r_end <= i_ctl.string_end;
        end else if (beat) begin
            r_q   <= r_q >> 8;
        end
    end

endmodule

// ----- bench/stream_find_replace_tb.sv -----
// Testbench for stream_find_replace: directed and random byte strings checked against a predictor.
`timescale 1ns / 1ps

module stream_find_replace_tb;
    import sfr_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int ITEM_TARGET   = 140;

    class rewrite_predictor;
        logic [63:0] pat_bytes;
        logic [3:0]  pat_len;
        logic [63:0] rep_bytes;
        logic [3:0]  rep_len;
        logic [7:0]  window [DEF_MAX_PATTERN];
        int          held;
        t_out        expected_beats [$];
        int          fail_count;

        function new();
            pat_bytes  = '0;
            pat_len    = 4'd1;
            rep_bytes  = '0;
            rep_len    = 4'd0;
            held       = 0;
            fail_count = 0;
        endfunction

        function int match_len();
            if (pat_len == 0) return 1;
            if (pat_len > DEF_MAX_PATTERN) return DEF_MAX_PATTERN;
            return int'(pat_len);
        endfunction

        function void write_reg(t_cfg_reg idx, logic [63:0] value);
            case (idx)
                CFG_PATTERN_BYTES: pat_bytes = value;
                CFG_PATTERN_LENGTH: begin
                    pat_len = value[3:0];
                    held    = 0;
                end
                CFG_REPLACEMENT_BYTES: rep_bytes = value;
                CFG_REPLACEMENT_LENGTH: rep_len = value[3:0];
                default: ;
            endcase
        endfunction

        function t_out byte_result(logic [7:0] v);
            t_out r;
            r.out_byte    = v;
            r.has_byte    = 1'b1;
            r.run_last    = 1'b0;
            r.string_done = 1'b0;
            return r;
        endfunction

        function void take_in_beat(t_in b);
            logic [7:0] win [DEF_MAX_PATTERN];
            t_out       produced [$];
            t_out       marker;
            int         plen;
            int         rlen;
            int         total;
            bit         hit;
            plen = match_len();
            rlen = (rep_len > DEF_MAX_REPLACEMENT) ? DEF_MAX_REPLACEMENT : int'(rep_len);
            if (held > plen - 1) held = plen - 1;
            for (int i = 0; i < held; i++) win[i] = window[i];
            win[held] = b.in_byte;
            total = held + 1;
            if (total == plen) begin
                hit = 1'b1;
                for (int i = 0; i < plen; i++) begin
                    if (win[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    for (int i = 0; i < rlen; i++) produced.push_back(byte_result(rep_bytes[8*i +: 8]));
                    total = 0;
                end else begin
                    produced.push_back(byte_result(win[0]));
                    for (int i = 1; i < total; i++) win[i-1] = win[i];
                    total--;
                end
            end
            if (b.in_last) begin
                for (int i = 0; i < total; i++) produced.push_back(byte_result(win[i]));
                total = 0;
                if (produced.size() == 0) begin
                    marker = '0;
                    produced.push_back(marker);
                end
                produced[produced.size()-1].string_done = 1'b1;
            end
            for (int i = 0; i < total; i++) window[i] = win[i];
            held = total;
            if (produced.size() != 0) produced[produced.size()-1].run_last = 1'b1;
            foreach (produced[i]) expected_beats.push_back(produced[i]);
        endfunction

        function void check_out_beat(t_out got);
            t_out want;
            if (expected_beats.size() == 0) begin
                $error("result beat %h arrived with nothing expected", got);
                fail_count++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                fail_count++;
            end
            if (got.has_byte !== want.has_byte) begin
                $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
                fail_count++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                fail_count++;
            end
            if (got.string_done !== want.string_done) begin
                $error("string_done: expected %0b, got %0b", want.string_done, got.string_done);
                fail_count++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in                    i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out                   o_out_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    rewrite_predictor rewrite = new();
    bit               sender_idles;
    bit               receiver_idles;
    bit               long_hold_req;
    int               items_sent;
    int               quiet_cycles;

    stream_find_replace DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) rewrite.check_out_beat(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("stream_find_replace_tb: FAIL");
                    $finish;
                end
            end
        end
    end

    // The receiver stalls in short random bursts, or once for a long stretch on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in in_beat(logic [7:0] v, logic last);
        t_in b;
        b.in_byte = v;
        b.in_last = last;
        return b;
    endfunction

    task automatic send_beat(t_in b);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        rewrite.take_in_beat(b);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_string(int n, bit finish);
        logic [7:0] text [$];
        int         plen;
        int         cut;
        int         r;
        plen = rewrite.match_len();
        while (text.size() < n) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, plen) : plen;
                for (int i = 0; i < cut; i++) text.push_back(rewrite.pat_bytes[8*i +: 8]);
            end else if (r < 8) begin
                text.push_back(rewrite.pat_bytes[8*$urandom_range(0, plen-1) +: 8]);
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (int i = 0; i < n; i++) send_beat(in_beat(text[i], finish && i == n - 1));
    endtask

    task automatic program_reg(t_cfg_reg idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        rewrite.write_reg(idx, value);
        @(negedge i_clk);
    endtask

    task automatic configure(logic [63:0] pat, logic [3:0] plen, logic [63:0] rep,
                             logic [3:0] rlen);
        program_reg(CFG_PATTERN_BYTES, pat);
        program_reg(CFG_PATTERN_LENGTH, {60'd0, plen});
        program_reg(CFG_REPLACEMENT_BYTES, rep);
        program_reg(CFG_REPLACEMENT_LENGTH, {60'd0, rlen});
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every expected beat has come, then lets the pipeline empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (rewrite.expected_beats.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [3:0] pick_pattern_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 4'($urandom_range(1, 3));
        if (r < 8) return 4'($urandom_range(4, 8));
        if (r == 8) return 4'd0;
        return 4'($urandom_range(9, 15));
    endfunction

    function automatic logic [3:0] pick_replacement_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return 4'($urandom_range(0, 8));
        if (r == 8) return 4'($urandom_range(9, 15));
        return 4'd0;
    endfunction

    initial begin
        int  phase;
        bit  final_stretch;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_PATTERN_BYTES;
        i_cfg_data     = '0;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        long_hold_req  = 1'b0;
        items_sent     = 0;
        quiet_cycles   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings delete every zero byte, so a lone zero ends a string empty.
        send_beat(in_beat(8'h00, 1'b1));
        send_beat(in_beat(8'hFF, 1'b0));
        send_beat(in_beat(8'h00, 1'b1));
        settle();

        configure(64'h6261, 4'd2, 64'hFFEE_DDCC_BBAA_9988, 4'd8);
        send_beat(in_beat(8'h61, 1'b0));
        send_beat(in_beat(8'h62, 1'b0));
        send_beat(in_beat(8'h61, 1'b0));
        send_beat(in_beat(8'h61, 1'b0));
        send_beat(in_beat(8'h62, 1'b0));
        send_beat(in_beat(8'h78, 1'b1));
        send_beat(in_beat(8'h61, 1'b1));
        settle();

        // A pattern length write in the middle of a string drops the held byte.
        send_beat(in_beat(8'h61, 1'b0));
        settle();
        program_reg(CFG_PATTERN_LENGTH, 64'd2);
        i_cfg_valid <= 1'b0;
        send_beat(in_beat(8'h62, 1'b1));
        settle();

        configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'h0, 4'd15);
        send_beat(in_beat(8'hFF, 1'b0));
        send_beat(in_beat(8'h7F, 1'b0));
        send_beat(in_beat(8'hFF, 1'b1));
        settle();

        configure(64'h0706_0504_0302_0100, 4'd15, 64'h0, 4'd9);
        for (int i = 0; i < 8; i++) send_beat(in_beat(8'(i), i == 7));
        settle();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            final_stretch  = items_sent >= ITEM_TARGET - 40;
            sender_idles   = !final_stretch && phase != 1 && $urandom_range(0, 2) != 0;
            receiver_idles = !final_stretch && $urandom_range(0, 2) != 0;
            if (phase == 1) begin
                configure({$urandom, $urandom}, 4'd1, {$urandom, $urandom}, 4'd8);
                long_hold_req = 1'b1;
                send_string(24, 1'b1);
            end else begin
                configure({$urandom, $urandom}, pick_pattern_len(), {$urandom, $urandom},
                          pick_replacement_len());
                repeat ($urandom_range(2, 5)) send_string($urandom_range(1, 12), 1'b1);
                if ($urandom_range(0, 3) == 0) send_string($urandom_range(1, 6), 1'b0);
            end
            settle();
            phase++;
        end

        if (rewrite.fail_count == 0 && rewrite.expected_beats.size() == 0) begin
            $display("stream_find_replace_tb: PASS");
        end else begin
            $display("stream_find_replace_tb: FAIL");
        end
        $finish;
    end

endmodule
